/* hw/rtl/lfu_pkg.sv */
// Shared types, constants and helpers for the frequency-ordered key/value cache.
// No dependencies; imported by the top level and the port checker.
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int KEY_W      = 32;
	localparam int DATA_W     = 32;
	localparam int CAP_W      = 5;

	localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W = ADDR_W;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CAP_W > OCC_W) ? CAP_W : OCC_W;

	localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(ENTRIES - 1);
	localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic              op;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] read_value;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
	} rsp_t;

	// One memory word per entry
	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [DATA_W-1:0]     data;
		logic [COUNT_BITS-1:0] count;
		logic [RANK_W-1:0]     rank;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Recency change left by the last item, applied lazily as the next scan passes each entry
	typedef struct packed {
		logic              active;
		logic              all_up;
		logic [ADDR_W-1:0] slot;
		logic [RANK_W-1:0] below;
	} rank_fix_t;

	function automatic logic [RANK_W-1:0] fix_rank(rank_fix_t f, logic [ADDR_W-1:0] a,
			logic [RANK_W-1:0] r);
		logic [RANK_W-1:0] res;
		res = r;
		if (f.active) begin
			if (a == f.slot) begin
				res = '0;
			end else if (f.all_up || (r < f.below)) begin
				res = r + 1'b1;
			end
		end
		return res;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

/* hw/rtl/lfu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/lfu_cache_lru_tiebreak_top.sv */
// Top level of the frequency-ordered key/value cache with recency tie break.
// Depends on lfu_pkg and lfu_ram.
//
//  channel  direction  handshake               payload
//  req      in         req_valid / req_stall   req_t  (op, key, value)
//  rsp      out        rsp_valid / rsp_stall   rsp_t  (found, read_value, evicted, evicted_key)
//  cfg      in         cfg_we                  cfg_wdata (capacity)
//
// A new item is accepted only once the previous one has left the decide state: a scan reads
// every entry word through the single read port of the entry memory, one per cycle.
// Reset clears the valid bits and the occupancy; the memory needs no clearing pass.
// A result still held by rsp_stall delays the end of the following item.
module lfu_cache_lru_tiebreak_top import lfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_DECIDE = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   capacity_q;
	logic [ENTRIES-1:0] valid_q;
	logic [OCC_W-1:0]   used_q;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic               proc_s1;
	logic [ADDR_W-1:0]  addr_s1;
	req_t               req_q;
	logic               hit_q;
	logic [ADDR_W-1:0]  hit_addr_q;
	entry_t             hit_ent_q;
	logic               vic_found_q;
	logic [ADDR_W-1:0]  vic_addr_q;
	entry_t             vic_ent_q;
	logic               free_found_q;
	logic [ADDR_W-1:0]  free_addr_q;
	rank_fix_t          fix_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [ENTRY_W-1:0] ram_rdata;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]  ram_waddr;
	logic               ram_we;

	entry_t             rd_ent;
	entry_t             adj_ent;
	logic               rd_vld;
	logic               is_hit;
	logic               beats;

	logic               accept;
	logic               decide_fire;
	logic [CMP_W-1:0]   cap_x;
	logic [CMP_W-1:0]   cap_eff;
	logic               cap_zero;
	logic               full;

	logic               wr_en;
	logic [ADDR_W-1:0]  wr_slot;
	entry_t             wr_ent;
	rsp_t               rsp_d;
	rank_fix_t          fix_d;
	logic               set_valid;
	logic               inc_used;

	assign accept      = (state_q == ST_IDLE) && req_valid;
	assign req_stall   = (state_q != ST_IDLE);
	assign decide_fire = (state_q == ST_DECIDE) && (!rsp_valid_q || !rsp_stall);

	// Stage 1: word of entry addr_s1 with the pending recency change applied
	assign rd_ent = entry_t'(ram_rdata);
	assign rd_vld = valid_q[addr_s1];

	always_comb begin
		adj_ent      = rd_ent;
		adj_ent.rank = fix_rank(fix_q, addr_s1, rd_ent.rank);
	end

	assign is_hit = rd_vld && (rd_ent.key == req_q.key);
	assign beats  = rd_vld && (!vic_found_q || (adj_ent.count < vic_ent_q.count) ||
		((adj_ent.count == vic_ent_q.count) && (adj_ent.rank > vic_ent_q.rank)));

	assign cap_x    = CMP_W'(capacity_q);
	assign cap_eff  = (cap_x > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_x;
	assign cap_zero = (cap_eff == '0);
	assign full     = (CMP_W'(used_q) >= cap_eff);

	always_comb begin
		wr_en          = 1'b0;
		wr_slot        = '0;
		wr_ent         = '0;
		rsp_d          = '0;
		fix_d          = '0;
		set_valid      = 1'b0;
		inc_used       = 1'b0;
		rsp_d.found    = hit_q;
		if (req_q.op == OP_GET) begin
			if (hit_q) begin
				rsp_d.read_value = hit_ent_q.data;
				wr_en            = 1'b1;
				wr_slot          = hit_addr_q;
				wr_ent           = hit_ent_q;
				wr_ent.count     = sat_inc(hit_ent_q.count);
				wr_ent.rank      = '0;
				fix_d.active     = 1'b1;
				fix_d.slot       = hit_addr_q;
				fix_d.below      = hit_ent_q.rank;
			end
		end else if (cap_zero) begin
			rsp_d.found = 1'b0;
		end else if (hit_q) begin
			wr_en        = 1'b1;
			wr_slot      = hit_addr_q;
			wr_ent       = hit_ent_q;
			wr_ent.data  = req_q.value;
			wr_ent.count = sat_inc(hit_ent_q.count);
			wr_ent.rank  = '0;
			fix_d.active = 1'b1;
			fix_d.slot   = hit_addr_q;
			fix_d.below  = hit_ent_q.rank;
		end else if (full) begin
			// Evict and refill the same slot: the others age as for a touch of the victim
			rsp_d.evicted     = 1'b1;
			rsp_d.evicted_key = vic_ent_q.key;
			wr_en             = 1'b1;
			wr_slot           = vic_addr_q;
			wr_ent.key        = req_q.key;
			wr_ent.data       = req_q.value;
			wr_ent.count      = COUNT_ONE;
			fix_d.active      = 1'b1;
			fix_d.slot        = vic_addr_q;
			fix_d.below       = vic_ent_q.rank;
		end else if (free_found_q) begin
			wr_en        = 1'b1;
			wr_slot      = free_addr_q;
			wr_ent.key   = req_q.key;
			wr_ent.data  = req_q.value;
			wr_ent.count = COUNT_ONE;
			fix_d.active = 1'b1;
			fix_d.all_up = 1'b1;
			fix_d.slot   = free_addr_q;
			set_valid    = 1'b1;
			inc_used     = 1'b1;
		end
	end

	// Scan write-back has the port while a word is in stage 1; the final write follows it
	assign ram_we    = proc_s1 || (decide_fire && wr_en);
	assign ram_waddr = proc_s1 ? addr_s1 : wr_slot;
	assign ram_wdata = proc_s1 ? adj_ent : wr_ent;

	lfu_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			capacity_q   <= CAP_RESET;
			valid_q      <= '0;
			used_q       <= '0;
			rd_addr_q    <= '0;
			proc_s1      <= 1'b0;
			hit_q        <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			fix_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= ST_SCAN;
						rd_addr_q    <= '0;
						hit_q        <= 1'b0;
						vic_found_q  <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					proc_s1 <= 1'b1;
					if (rd_addr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					proc_s1 <= 1'b0;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (decide_fire) begin
						state_q <= ST_IDLE;
						fix_q   <= fix_d;
						if (set_valid) begin
							valid_q[wr_slot] <= 1'b1;
						end
						if (inc_used) begin
							used_q <= used_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (proc_s1) begin
				if (is_hit) begin
					hit_q <= 1'b1;
				end
				if (beats) begin
					vic_found_q <= 1'b1;
				end
				if (!rd_vld && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (decide_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		addr_s1 <= rd_addr_q;
		if (proc_s1) begin
			if (is_hit) begin
				hit_addr_q <= addr_s1;
				hit_ent_q  <= adj_ent;
			end
			if (beats) begin
				vic_addr_q <= addr_s1;
				vic_ent_q  <= adj_ent;
			end
			if (!rd_vld && !free_found_q) begin
				free_addr_q <= addr_s1;
			end
		end
		if (decide_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/lfu_checker.sv */
// Port-level checks for the cache top level, attached by the bind at the end.
// Depends on lfu_pkg and lfu_cache_lru_tiebreak_top.
module lfu_checker import lfu_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input rsp_t             rsp
);

	// An accepted item keeps the input closed while it is scanned
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("input open right after an item was accepted");

	a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.found && rsp.evicted))
		else $error("eviction reported for a key that was present");

	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.evicted) |-> (rsp.evicted_key == '0))
		else $error("evicted key set without an eviction");

	a_miss_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |-> (rsp.read_value == '0))
		else $error("read value set on a miss");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result item changed or dropped");

endmodule

bind lfu_cache_lru_tiebreak_top lfu_checker u_lfu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
